FILE: hdl/ps2mc_pkg.sv
package ps2mc_pkg;

  // Cursor coordinate width; limits and positions follow it.
  localparam int COORD_BITS = 12;

  // Configuration port widths.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int GAIN_W     = 5;

  // Depth of each internal request queue.
  localparam int QDEPTH = 2;
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = CFG_IDX_W'(3);

  // Reset values.
  localparam logic [COORD_BITS-1:0] RIGHT_RST  = COORD_BITS'(1023);
  localparam logic [COORD_BITS-1:0] BOTTOM_RST = COORD_BITS'(767);
  localparam logic [COORD_BITS-1:0] POS_X_RST  = COORD_BITS'(512);
  localparam logic [COORD_BITS-1:0] POS_Y_RST  = COORD_BITS'(384);
  localparam logic [GAIN_W-1:0]     GAIN_RST   = GAIN_W'(1);

  // Event codes reported with every result.
  localparam logic [2:0] EV_IGNORED  = 3'd0;
  localparam logic [2:0] EV_DISCARD  = 3'd1;
  localparam logic [2:0] EV_STORED   = 3'd2;
  localparam logic [2:0] EV_APPLIED  = 3'd3;
  localparam logic [2:0] EV_OVERFLOW = 3'd4;

  // Position within a three-byte packet.
  localparam logic [1:0] IDX_FIRST  = 2'd0;
  localparam logic [1:0] IDX_SECOND = 2'd1;
  localparam logic [1:0] IDX_THIRD  = 2'd2;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       from_aux;
  } in_item_t;

  typedef struct packed {
    logic [2:0]            event_res;
    logic [COORD_BITS-1:0] cursor_x;
    logic [COORD_BITS-1:0] cursor_y;
    logic [2:0]            button_bits;
    logic                  left_clicked;
    logic                  right_clicked;
    logic                  left_released;
  } out_item_t;

  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // Classified request handed from the front end to the cursor engine.
  typedef struct packed {
    logic [2:0] event_res;
    logic [2:0] buttons;
    logic [8:0] dx;
    logic [8:0] dy;
  } cmd_t;

endpackage

FILE: hdl/ps2mc_front.sv
module ps2mc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  ps2mc_pkg::in_item_t in_item,
  input  logic                in_push,
  output logic                in_full,
  input  ps2mc_pkg::cfg_wr_t  cfg_wr,
  output ps2mc_pkg::cmd_t     cmd_head,
  output logic                cmd_valid,
  input  logic                cmd_pop
);
  import ps2mc_pkg::*;

  logic              enable_r;
  logic [1:0]        byte_idx_r;
  logic [1:0]        byte_idx_nxt;
  logic [7:0]        pkt0_r;
  logic [7:0]        pkt1_r;
  logic              store0;
  logic              store1;
  cmd_t              cmd_new;
  cmd_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              accept;

  assign in_full   = (count_r == QCNT_W'(QDEPTH));
  assign cmd_valid = (count_r != '0);
  assign cmd_head  = q_mem[rd_ptr_r];
  assign accept    = in_push && !in_full;

  // Enable register lives with the classifier.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
    end else if (cfg_wr.valid && (cfg_wr.index == REG_ENABLE)) begin
      enable_r <= cfg_wr.data[0];
    end
  end

  // Classify the incoming byte against the packet position.
  always_comb begin
    byte_idx_nxt      = byte_idx_r;
    store0            = 1'b0;
    store1            = 1'b0;
    cmd_new.event_res = EV_IGNORED;
    cmd_new.buttons   = pkt0_r[2:0];
    cmd_new.dx        = {pkt0_r[4], pkt1_r};
    cmd_new.dy        = {pkt0_r[5], in_item.rx_byte};
    if (enable_r && in_item.from_aux) begin
      case (byte_idx_r)
        IDX_SECOND: begin
          store1            = 1'b1;
          byte_idx_nxt      = IDX_THIRD;
          cmd_new.event_res = EV_STORED;
        end
        IDX_THIRD: begin
          byte_idx_nxt      = IDX_FIRST;
          cmd_new.event_res = (pkt0_r[7:6] != 2'b00) ? EV_OVERFLOW : EV_APPLIED;
        end
        default: begin
          // The first byte must carry the sync bit.
          if (in_item.rx_byte[3]) begin
            store0            = 1'b1;
            byte_idx_nxt      = IDX_SECOND;
            cmd_new.event_res = EV_STORED;
          end else begin
            byte_idx_nxt      = IDX_FIRST;
            cmd_new.event_res = EV_DISCARD;
          end
        end
      endcase
    end
  end

  // Packet assembly state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_idx_r <= IDX_FIRST;
    end else if (accept) begin
      byte_idx_r <= byte_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store0) begin
      pkt0_r <= in_item.rx_byte;
    end
    if (accept && store1) begin
      pkt1_r <= in_item.rx_byte;
    end
  end

  // Request queue toward the cursor engine.
  always_ff @(posedge clk) begin
    if (accept) begin
      q_mem[wr_ptr_r] <= cmd_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (accept) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (cmd_pop && cmd_valid) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + QCNT_W'(accept) - QCNT_W'(cmd_pop && cmd_valid);
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("front queue count out of range");
  a_idx_valid: assert property (@(posedge clk) disable iff (!rst_n)
    byte_idx_r != 2'd3)
    else $error("packet byte index reached an unused code");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) && !accept |=> (count_r == '0))
    else $error("front queue count changed without a request");
`endif

endmodule

FILE: hdl/ps2mc_back.sv
module ps2mc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ps2mc_pkg::cfg_wr_t   cfg_wr,
  input  ps2mc_pkg::cmd_t      cmd_head,
  input  logic                 cmd_valid,
  output logic                 cmd_pop,
  output ps2mc_pkg::out_item_t out_item,
  output logic                 out_empty,
  input  logic                 out_pop
);
  import ps2mc_pkg::*;

  localparam int SUM_W = COORD_BITS + 18;

  logic [COORD_BITS-1:0] right_lim_r;
  logic [COORD_BITS-1:0] bottom_lim_r;
  logic [GAIN_W-1:0]     gain_r;
  logic [COORD_BITS-1:0] pos_x_r;
  logic [COORD_BITS-1:0] pos_y_r;
  logic [2:0]            held_r;
  logic [2:0]            earlier_r;
  logic [COORD_BITS-1:0] pos_x_nxt;
  logic [COORD_BITS-1:0] pos_y_nxt;
  logic [2:0]            held_nxt;
  logic [2:0]            earlier_nxt;
  logic signed [9:0]     dx_s;
  logic signed [9:0]     dy_s;
  logic [COORD_BITS-1:0] moved_x;
  logic [COORD_BITS-1:0] moved_y;
  logic [COORD_BITS:0]   right_sum;
  logic [COORD_BITS:0]   bottom_sum;
  out_item_t             res_new;
  out_item_t             r_mem [QDEPTH];
  logic [QPTR_W-1:0]     wr_ptr_r;
  logic [QPTR_W-1:0]     rd_ptr_r;
  logic [QCNT_W-1:0]     count_r;
  logic                  res_full;
  logic                  do_pop;

  // Scale a delta, add it to the position and clamp to [0, limit].
  function automatic logic [COORD_BITS-1:0] move_axis(
    input logic [COORD_BITS-1:0] pos,
    input logic signed [9:0]     d,
    input logic [GAIN_W-1:0]     g,
    input logic [COORD_BITS-1:0] lim
  );
    logic signed [15:0]    prod;
    logic signed [SUM_W-1:0] sum;
    logic [COORD_BITS-1:0] r;
    prod = d * $signed({1'b0, g});
    sum  = $signed({1'b0, pos}) + prod;
    if (sum < 0) begin
      r = '0;
    end else if (sum > $signed({1'b0, lim})) begin
      r = lim;
    end else begin
      r = sum[COORD_BITS-1:0];
    end
    return r;
  endfunction

  assign res_full  = (count_r == QCNT_W'(QDEPTH));
  assign out_empty = (count_r == '0);
  assign out_item  = r_mem[rd_ptr_r];
  assign do_pop    = cmd_valid && !res_full;
  assign cmd_pop   = do_pop;

  assign right_sum  = {1'b0, cfg_wr.data[COORD_BITS-1:0]} + 1'b1;
  assign bottom_sum = {1'b0, cfg_wr.data[COORD_BITS-1:0]} + 1'b1;

  // Deltas: X as sent, Y inverted so that screen down is positive.
  assign dx_s    = {cmd_head.dx[8], cmd_head.dx};
  assign dy_s    = -$signed({cmd_head.dy[8], cmd_head.dy});
  assign moved_x = move_axis(pos_x_r, dx_s, gain_r, right_lim_r);
  assign moved_y = move_axis(pos_y_r, dy_s, gain_r, bottom_lim_r);

  // Next cursor and button state for the request at the head.
  always_comb begin
    pos_x_nxt   = pos_x_r;
    pos_y_nxt   = pos_y_r;
    held_nxt    = held_r;
    earlier_nxt = earlier_r;
    if ((cmd_head.event_res == EV_APPLIED) || (cmd_head.event_res == EV_OVERFLOW)) begin
      earlier_nxt = held_r;
      held_nxt    = cmd_head.buttons;
    end
    if (cmd_head.event_res == EV_APPLIED) begin
      pos_x_nxt = moved_x;
      pos_y_nxt = moved_y;
    end
    res_new.event_res     = cmd_head.event_res;
    res_new.cursor_x      = pos_x_nxt;
    res_new.cursor_y      = pos_y_nxt;
    res_new.button_bits   = held_nxt;
    res_new.left_clicked  = held_nxt[0] & ~earlier_nxt[0];
    res_new.right_clicked = held_nxt[1] & ~earlier_nxt[1];
    res_new.left_released = ~held_nxt[0] & earlier_nxt[0];
  end

  // Configuration and cursor state; a limit write recenters its axis.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      right_lim_r  <= RIGHT_RST;
      bottom_lim_r <= BOTTOM_RST;
      gain_r       <= GAIN_RST;
      pos_x_r      <= POS_X_RST;
      pos_y_r      <= POS_Y_RST;
      held_r       <= '0;
      earlier_r    <= '0;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        REG_RIGHT: begin
          right_lim_r <= cfg_wr.data[COORD_BITS-1:0];
          pos_x_r     <= right_sum[COORD_BITS:1];
        end
        REG_BOTTOM: begin
          bottom_lim_r <= cfg_wr.data[COORD_BITS-1:0];
          pos_y_r      <= bottom_sum[COORD_BITS:1];
        end
        REG_GAIN: begin
          gain_r <= cfg_wr.data[GAIN_W-1:0];
        end
        default: begin
        end
      endcase
    end else if (do_pop) begin
      pos_x_r   <= pos_x_nxt;
      pos_y_r   <= pos_y_nxt;
      held_r    <= held_nxt;
      earlier_r <= earlier_nxt;
    end
  end

  // Result queue toward the output side.
  always_ff @(posedge clk) begin
    if (do_pop) begin
      r_mem[wr_ptr_r] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_pop) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (out_pop && !out_empty) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + QCNT_W'(do_pop) - QCNT_W'(out_pop && !out_empty);
    end
  end

`ifndef ASSERT_OFF
  a_x_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_x_r <= right_lim_r)
    else $error("cursor x beyond right limit");
  a_y_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_y_r <= bottom_lim_r)
    else $error("cursor y beyond bottom limit");
  a_result_appears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_valid && out_empty |=> !out_empty)
    else $error("request at head did not produce a result");
`endif

endmodule

FILE: hdl/ps2_mouse_packet_cursor.sv
// PS/2 mouse packet decoder with a clamped screen cursor.
// Input channel: push one controller byte with its auxiliary flag per request
// while in_full is low. Bytes that are not mouse data, or that arrive while the
// block is disabled, still produce a result with the "ignored" event.
// Result channel: every input request yields exactly one result, in order. The
// oldest result sits on out_item while out_empty is low and leaves on out_pop.
// Configuration: cfg_ready is always high; writes are meant for idle periods.
// Writing a limit register recenters that cursor axis.
// An accepted byte's request passes the front queue, then the cursor engine and
// the result queue, before its result shows on out_item. Throughput: one byte per
// cycle while in_full is low; the cursor engine retires one request per cycle
// while the result queue has room, via one scale, add and clamp stage per axis.
// A two-entry queue sits between the byte classifier and the cursor engine, and
// another on the result side. When the receiver stalls, results collect there
// and in_full rises once both queues are full; nothing is dropped.
// Reset: disabled, limits 1023 by 767, gain 1, cursor at 512/384, no buttons
// held and packet assembly at the first byte. Queues are emptied.
module ps2_mouse_packet_cursor (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  ps2mc_pkg::in_item_t                   in_item,
  input  logic                                  in_push,
  output logic                                  in_full,
  output ps2mc_pkg::out_item_t                  out_item,
  output logic                                  out_empty,
  input  logic                                  out_pop,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ps2mc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ps2mc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import ps2mc_pkg::*;

  cfg_wr_t cfg_wr;
  cmd_t    cmd_head;
  logic    cmd_valid;
  logic    cmd_pop;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  // Byte classifier and packet assembly.
  ps2mc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .in_push   (in_push),
    .in_full   (in_full),
    .cfg_wr    (cfg_wr),
    .cmd_head  (cmd_head),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  // Cursor and button engine with the result queue.
  ps2mc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .cmd_head  (cmd_head),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .out_item  (out_item),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

endmodule
